@@ rtl/core/hph_pkg.sv @@
// ----------------------------------------------------------------------------
// hph_pkg
// Shared constants and the level-state entry type for the hierarchical
// polynomial hash.
// ----------------------------------------------------------------------------
package hph_pkg;

    // Default geometry of the hash tree
    localparam int BLOCK_SIZE_DEF = 32;
    localparam int MAX_LEVELS_DEF = 6;

    // Data and fill-count widths
    localparam int DATA_W = 64;
    localparam int FILL_W = 6;

    // Hash multiplier and the saturation point of the top-level fill count
    localparam logic [DATA_W-1:0] HASH_MUL     = 64'd31;
    localparam logic [FILL_W-1:0] TOP_FILL_CAP = 6'd63;

    // One level of the tree as held in the state memory
    typedef struct packed {
        logic [DATA_W-1:0] acc;
        logic [FILL_W-1:0] fill;
        logic              emitted;
    } level_t;

    // Value of a level after reset or after a result
    localparam level_t LEVEL_RST = '{acc: 64'd1, fill: '0, emitted: 1'b0};

endpackage

@@ rtl/core/hierarchical_polynomial_hash.sv @@
// ----------------------------------------------------------------------------
// hierarchical_polynomial_hash
// Base-31 rolling hash over 64-bit words arranged as a tree of block hashes.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one array element per beat in s_tdata, with
//   s_tlast on the final element. Level 0 hashes each run of BLOCK_SIZE words
//   as r = 1, r = 31*r + v (mod 2^64); each closed block hash feeds level 1,
//   and so on. On the last word the open blocks are flushed upward and the
//   single remaining hash is sent as one beat on the master stream.
//   Each word is accepted with a read of its level 0 state, then updated and
//   written back before the next word is taken. Each block that closes adds
//   a read and update of the next level. The final word adds a read and check
//   of every level visited by the flush, plus a read and update for every
//   value pushed upward during it; the result is registered once the last
//   level is examined and the output register is free. The state memory read
//   is registered: a visit is a read, then a write back or (flush) a check.
//   The result sits in an output register, so the next array is accepted while
//   it waits. If a second result is due while the first is still stalled, the
//   sequencer holds until m_tready frees the register.
//   Reset (aresetn low, synchronous) clears the per-level valid bits, so every
//   level reads as its reset value at once; no clearing pass is needed. The
//   same bits are cleared after each result to start the next array.
// ----------------------------------------------------------------------------
module hierarchical_polynomial_hash #(
    parameter int BLOCK_SIZE = hph_pkg::BLOCK_SIZE_DEF,
    parameter int MAX_LEVELS = hph_pkg::MAX_LEVELS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Slave stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic signed [hph_pkg::DATA_W-1:0] s_tdata,   // [63:0] element
    input  logic                            s_tlast,   // is_last
    // Master stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic signed [hph_pkg::DATA_W-1:0] m_tdata    // [63:0] hash
);

    localparam int LVL_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam logic [LVL_W-1:0] TOP_LVL = LVL_W'(MAX_LEVELS - 1);
    localparam logic [hph_pkg::FILL_W:0] BLK_CNT = (hph_pkg::FILL_W + 1)'(BLOCK_SIZE);

    // Sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RD   = 2'd1;
    localparam logic [1:0] ST_EXEC = 2'd2;

    // Operation codes
    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    logic [1:0]                  state_reg, state_next;
    logic                        op_reg, op_next;
    logic                        last_reg, last_next;
    logic                        fl_act_reg, fl_act_next;
    logic [LVL_W-1:0]            lvl_reg, lvl_next;
    logic [LVL_W-1:0]            fl_idx_reg, fl_idx_next;
    logic [hph_pkg::DATA_W-1:0]  val_reg, val_next;
    logic [MAX_LEVELS-1:0]       vld_reg, vld_next;
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [hph_pkg::DATA_W-1:0]  m_tdata_reg, m_tdata_next;

    // State memory
    hph_pkg::level_t             mem [MAX_LEVELS];
    hph_pkg::level_t             rd_data_reg;
    logic                        rd_vld_reg;
    logic                        rd_en;
    logic [LVL_W-1:0]            rd_addr;
    logic                        wr_en;
    hph_pkg::level_t             wr_data;

    hph_pkg::level_t             ent;
    logic [hph_pkg::DATA_W-1:0]  acc_new;
    logic [hph_pkg::FILL_W:0]    fill_inc;
    logic                        at_top;
    logic                        out_busy;
    logic                        load_out;
    logic                        s_acc;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign out_busy = m_tvalid_reg && !m_tready;

    // Read level 0 on accept, the current level in the read state
    assign rd_en   = s_acc || (state_reg == ST_RD);
    assign rd_addr = (state_reg == ST_RD) ? lvl_reg : '0;

    // Entries not written since the last result read as reset
    assign ent      = rd_vld_reg ? rd_data_reg : hph_pkg::LEVEL_RST;
    assign acc_new  = (ent.acc << 5) - ent.acc + val_reg;
    assign fill_inc = {1'b0, ent.fill} + 1'b1;
    assign at_top   = (lvl_reg == TOP_LVL);

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        last_next     = last_reg;
        fl_act_next   = fl_act_reg;
        lvl_next      = lvl_reg;
        fl_idx_next   = fl_idx_reg;
        val_next      = val_reg;
        vld_next      = vld_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        wr_en         = 1'b0;
        wr_data       = ent;
        load_out      = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    val_next    = s_tdata;
                    last_next   = s_tlast;
                    op_next     = OP_PUSH;
                    fl_act_next = 1'b0;
                    lvl_next    = '0;
                    state_next  = ST_EXEC;
                end
            end
            ST_RD: begin
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (op_reg == OP_PUSH) begin
                    wr_en = 1'b1;
                    if (!at_top && fill_inc == BLK_CNT) begin
                        // Close the block and carry its hash up one level
                        wr_data    = '{acc: 64'd1, fill: '0, emitted: 1'b1};
                        val_next   = acc_new;
                        lvl_next   = lvl_reg + 1'b1;
                        state_next = ST_RD;
                    end else begin
                        wr_data.acc = acc_new;
                        if (at_top) begin
                            wr_data.fill = (ent.fill == hph_pkg::TOP_FILL_CAP) ?
                                           ent.fill : fill_inc[hph_pkg::FILL_W-1:0];
                        end else begin
                            wr_data.fill = fill_inc[hph_pkg::FILL_W-1:0];
                        end
                        if (fl_act_reg) begin
                            op_next    = OP_FLUSH;
                            lvl_next   = fl_idx_reg;
                            state_next = ST_RD;
                        end else if (last_reg) begin
                            op_next    = OP_FLUSH;
                            lvl_next   = '0;
                            state_next = ST_RD;
                        end else begin
                            state_next = ST_IDLE;
                        end
                    end
                end else begin
                    if ((lvl_reg != '0 && !ent.emitted && ent.fill == 1) ||
                        at_top || !ent.emitted) begin
                        // Result found: wait for a free output register
                        if (!out_busy) begin
                            load_out      = 1'b1;
                            m_tvalid_next = 1'b1;
                            m_tdata_next  = (lvl_reg != '0 && !ent.emitted &&
                                             ent.fill == 1) ?
                                            ent.acc - hph_pkg::HASH_MUL : ent.acc;
                            vld_next      = '0;
                            fl_act_next   = 1'b0;
                            state_next    = ST_IDLE;
                        end
                    end else if (ent.fill != '0) begin
                        // Push the open block hash into the next level
                        val_next    = ent.acc;
                        lvl_next    = lvl_reg + 1'b1;
                        fl_idx_next = lvl_reg + 1'b1;
                        fl_act_next = 1'b1;
                        op_next     = OP_PUSH;
                        state_next  = ST_RD;
                    end else begin
                        lvl_next   = lvl_reg + 1'b1;
                        state_next = ST_RD;
                    end
                end
                if (wr_en) begin
                    vld_next[lvl_reg] = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            op_reg       <= OP_PUSH;
            last_reg     <= 1'b0;
            fl_act_reg   <= 1'b0;
            lvl_reg      <= '0;
            fl_idx_reg   <= '0;
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            op_reg       <= op_next;
            last_reg     <= last_next;
            fl_act_reg   <= fl_act_next;
            lvl_reg      <= lvl_next;
            fl_idx_reg   <= fl_idx_next;
            vld_reg      <= vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        val_reg     <= val_next;
        m_tdata_reg <= m_tdata_next;
    end

    // State memory: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[lvl_reg] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
            rd_vld_reg  <= vld_reg[rd_addr];
        end
    end

    // Level pointer stays inside the memory
    a_lvl_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (int'(lvl_reg) < MAX_LEVELS))
        else $error("level pointer out of range");

    // A result is only produced while flushing a closed array
    a_out_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |-> (op_reg == OP_FLUSH) && last_reg)
        else $error("result outside a flush");

    // A stalled result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |-> !out_busy)
        else $error("output register overwritten");

    // Every level reads as reset once a result is out
    a_clear_after_out: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> (vld_reg == '0) && (state_reg == ST_IDLE))
        else $error("level state not cleared after result");

endmodule
